/* sv/hdt_pkg.sv */
// Shared types, constants and the dot radius table of the halftone screen texel block.
// Used by every module of the block; depends on nothing else.
package hdt_pkg;

    localparam int MAX_SIZE_LOG2 = 8;
    localparam int MAX_LEVELS    = 16;
    localparam int TILE_LOG2     = 3;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int DIV_STEPS     = 8;

    localparam logic [0:0] REG_TEX_SHIFT   = 1'd0;
    localparam logic [0:0] REG_LEVEL_COUNT = 1'd1;

    localparam logic [63:0] QUARTER_PI_Q16 = 64'd51472;
    localparam logic [63:0] SQRT2_M1_Q16   = 64'd27146;
    localparam logic [63:0] ONE_Q16        = 64'd65536;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_FULL,
        KIND_RAMP
    } kind_t;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] radius;
        logic [5:0] dsum;
    } task_t;

    typedef logic [16:0] rad_tab_t [256];

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_w;
        v     = val;
        res   = '0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v   = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    // Dot radius as a Q1.16 fraction of the half tile, indexed by
    // {levels - 1, level}. The radius in 1/32 texel is this value times the
    // tile width over 4096. Entries outside the ramp range are never used.
    function automatic rad_tab_t build_rad_tab();
        rad_tab_t    tab;
        logic [63:0] b;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] x;
        for (int nm = 0; nm < 16; nm++) begin
            for (int lv = 0; lv < 16; lv++) begin
                x = '0;
                if (nm >= 1 && lv >= 1 && lv < nm) begin
                    b = (64'(lv) * ONE_Q16) / 64'(nm + 1);
                    if (b < QUARTER_PI_Q16) begin
                        r = (b * ONE_Q16) / QUARTER_PI_Q16;
                        x = isqrt64(r * ONE_Q16);
                    end else begin
                        t = ((b - QUARTER_PI_Q16) * ONE_Q16) / (ONE_Q16 - QUARTER_PI_Q16);
                        x = ONE_Q16 + (SQRT2_M1_Q16 * t) / ONE_Q16;
                    end
                end
                tab[nm * 16 + lv] = x[16:0];
            end
        end
        return tab;
    endfunction

    localparam rad_tab_t RAD_TAB = build_rad_tab();

endpackage

/* sv/halftone_dot_screen_texel.sv */
// Top level of the clustered-dot halftone screen texel generator.
// Holds the configuration registers; depends on hdt_pkg, hdt_front, hdt_fifo, hdt_back.
//
// Usage:
//   Input channel s_valid/s_ready carries one texel request: a brightness
//   level and a texel column and row. Output channel m_valid/m_ready carries
//   one coverage byte per request, in request order.
//   Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
//   (0: texture size shift, 1: level count) at the clock edge; write only while idle.
//   Throughput: one texel per clock unless the receiver stalls. The front
//   classifies in the accept cycle and pushes into a four entry queue; the
//   back runs a ramp compare stage and an eight stage restoring divider, one
//   quotient bit per stage.
//   Reset (aresetn low, synchronous) empties the queue and the pipeline and
//   sets the texture size shift to 8 and the level count to 16.
//   When the receiver stalls the whole back pipeline holds; the queue keeps
//   taking items until it is full, then s_ready goes low.
module halftone_dot_screen_texel (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [3:0] s_level,
    input  logic [7:0] s_pos_x,
    input  logic [7:0] s_pos_y,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_coverage,
    input  logic       cfg_wr_en,
    input  logic [0:0] cfg_index,
    input  logic [4:0] cfg_wdata
);

    logic [3:0]     tex_shift_reg;
    logic [4:0]     level_count_reg;
    hdt_pkg::task_t front_item;
    hdt_pkg::task_t pop_data;
    logic           full;
    logic           empty;
    logic           pop;
    logic           push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tex_shift_reg   <= 4'd8;
            level_count_reg <= 5'd16;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                hdt_pkg::REG_TEX_SHIFT:   tex_shift_reg   <= cfg_wdata[3:0];
                hdt_pkg::REG_LEVEL_COUNT: level_count_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_ready = !full;
    assign push    = s_valid && !full;

    hdt_front u_front (
        .tex_shift   (tex_shift_reg),
        .level_count (level_count_reg),
        .level       (s_level),
        .pos_x       (s_pos_x),
        .pos_y       (s_pos_y),
        .item        (front_item)
    );

    hdt_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_item),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    hdt_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .empty      (empty),
        .pop_data   (pop_data),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_coverage (m_coverage)
    );

endmodule

/* sv/hdt_front.sv */
// Front end of the halftone screen: clamps the registers, classifies the item
// and finds the dot radius and the squared folded corner distance. Uses hdt_pkg.
module hdt_front (
    input  logic [3:0]     tex_shift,
    input  logic [4:0]     level_count,
    input  logic [3:0]     level,
    input  logic [7:0]     pos_x,
    input  logic [7:0]     pos_y,
    output hdt_pkg::task_t item
);

    logic [3:0]  sl;
    logic [1:0]  cl;
    logic [3:0]  nlm1;
    logic [2:0]  mask;
    logic [2:0]  xm;
    logic [2:0]  ym;
    logic [2:0]  half;
    logic [2:0]  dx;
    logic [2:0]  dy;
    logic [3:0]  csz;
    logic [16:0] xr;
    logic [19:0] scaled;
    logic [7:0]  radius;

    always_comb begin
        sl = (tex_shift > 4'(hdt_pkg::MAX_SIZE_LOG2)) ? 4'(hdt_pkg::MAX_SIZE_LOG2) : tex_shift;
        cl = (sl >= 4'(hdt_pkg::TILE_LOG2)) ? 2'(hdt_pkg::TILE_LOG2) : sl[1:0];
        if (level_count < 5'd2) begin
            nlm1 = 4'd1;
        end else if (level_count > 5'(hdt_pkg::MAX_LEVELS)) begin
            nlm1 = 4'(hdt_pkg::MAX_LEVELS - 1);
        end else begin
            nlm1 = 4'(level_count - 5'd1);
        end
        csz  = 4'd1 << cl;
        mask = 3'(csz - 4'd1);
        half = 3'(csz >> 1);
        xm   = pos_x[2:0] & mask;
        ym   = pos_y[2:0] & mask;
        dx   = (xm <= half) ? xm : 3'(csz - {1'b0, xm});
        dy   = (ym <= half) ? ym : 3'(csz - {1'b0, ym});

        xr     = hdt_pkg::RAD_TAB[{nlm1, level}];
        scaled = {3'b000, xr} << cl;
        radius = scaled[19:12];

        item.radius = radius;
        item.dsum   = 6'({3'b000, dx} * {3'b000, dx}) + 6'({3'b000, dy} * {3'b000, dy});
        if (level == 4'd0) begin
            item.kind = hdt_pkg::KIND_ZERO;
        end else if (level >= nlm1) begin
            item.kind = hdt_pkg::KIND_FULL;
        end else if (radius == 8'd0) begin
            item.kind = hdt_pkg::KIND_ZERO;
        end else begin
            item.kind = hdt_pkg::KIND_RAMP;
        end
    end

endmodule

/* sv/hdt_fifo.sv */
// Short queue between the front and the back of the halftone screen.
// Holds classified items; uses hdt_pkg.
module hdt_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  hdt_pkg::task_t push_data,
    input  logic           pop,
    output hdt_pkg::task_t pop_data,
    output logic           full,
    output logic           empty
);

    hdt_pkg::task_t                  mem_reg [hdt_pkg::FIFO_DEPTH];
    logic [hdt_pkg::FIFO_AW-1:0]     wr_ptr_reg;
    logic [hdt_pkg::FIFO_AW-1:0]     wr_ptr_next;
    logic [hdt_pkg::FIFO_AW-1:0]     rd_ptr_reg;
    logic [hdt_pkg::FIFO_AW-1:0]     rd_ptr_next;
    logic [hdt_pkg::FIFO_AW:0]       count_reg;
    logic [hdt_pkg::FIFO_AW:0]       count_next;

    assign full     = (count_reg == (hdt_pkg::FIFO_AW+1)'(hdt_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (hdt_pkg::FIFO_AW+1)'(hdt_pkg::FIFO_DEPTH))
        else $error("queue count beyond its depth");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("pop from an empty queue");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");

endmodule

/* sv/hdt_back.sv */
// Back end of the halftone screen: ramp band compare and a pipelined
// restoring divider for the antialiased edge, then the output register. Uses hdt_pkg.
module hdt_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           empty,
    input  hdt_pkg::task_t pop_data,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_coverage
);

    localparam int NS = hdt_pkg::DIV_STEPS;

    logic           en;
    logic           a_vld_reg;
    hdt_pkg::task_t a_reg;

    logic           dv_vld_reg  [NS+1];
    hdt_pkg::kind_t dv_kind_reg [NS+1];
    logic [23:0]    dv_rem_reg  [NS+1];
    logic [13:0]    dv_den_reg  [NS+1];
    logic [7:0]     dv_q_reg    [NS+1];

    logic           dv_vld_next  [NS+1];
    hdt_pkg::kind_t dv_kind_next [NS+1];
    logic [23:0]    dv_rem_next  [NS+1];
    logic [13:0]    dv_den_next  [NS+1];
    logic [7:0]     dv_q_next    [NS+1];

    logic           out_vld_reg;
    logic [7:0]     out_cov_reg;
    logic [7:0]     out_cov_next;

    logic [8:0]     rp;
    logic [15:0]    hi;
    logic [15:0]    lo;
    logic [15:0]    d;
    logic [15:0]    diff;
    logic [23:0]    trial;

    assign en         = !out_vld_reg || m_ready;
    assign pop        = en && !empty;
    assign m_valid    = out_vld_reg;
    assign m_coverage = out_cov_reg;

    always_comb begin
        // Band edges: hi - lo is always 64 * radius.
        rp   = {1'b0, a_reg.radius} + 9'd16;
        hi   = 16'({7'b0, rp} * {7'b0, rp});
        lo   = hi - {2'b00, a_reg.radius, 6'b0};
        d    = {a_reg.dsum, 10'b0};
        diff = hi - d;
        dv_vld_next[0]  = a_vld_reg;
        dv_den_next[0]  = {a_reg.radius, 6'b0};
        dv_rem_next[0]  = {diff, 8'b0} - {8'b0, diff};
        dv_q_next[0]    = '0;
        dv_kind_next[0] = a_reg.kind;
        if (a_reg.kind == hdt_pkg::KIND_RAMP) begin
            if (d < lo) begin
                dv_kind_next[0] = hdt_pkg::KIND_FULL;
            end else if (d >= hi) begin
                dv_kind_next[0] = hdt_pkg::KIND_ZERO;
            end
        end
        for (int k = 1; k <= NS; k++) begin
            trial           = {10'b0, dv_den_reg[k-1]} << (NS - k);
            dv_vld_next[k]  = dv_vld_reg[k-1];
            dv_kind_next[k] = dv_kind_reg[k-1];
            dv_den_next[k]  = dv_den_reg[k-1];
            dv_q_next[k]    = dv_q_reg[k-1];
            dv_rem_next[k]  = dv_rem_reg[k-1];
            if (dv_rem_reg[k-1] >= trial) begin
                dv_rem_next[k]           = dv_rem_reg[k-1] - trial;
                dv_q_next[k][NS - k]     = 1'b1;
            end
        end
        case (dv_kind_reg[NS])
            hdt_pkg::KIND_ZERO: out_cov_next = 8'd0;
            hdt_pkg::KIND_FULL: out_cov_next = 8'd255;
            hdt_pkg::KIND_RAMP: out_cov_next = dv_q_reg[NS];
            default:            out_cov_next = 8'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k <= NS; k++) dv_vld_reg[k] <= 1'b0;
        end else if (en) begin
            a_vld_reg   <= !empty;
            out_vld_reg <= dv_vld_reg[NS];
            for (int k = 0; k <= NS; k++) dv_vld_reg[k] <= dv_vld_next[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg       <= pop_data;
            out_cov_reg <= out_cov_next;
            for (int k = 0; k <= NS; k++) begin
                dv_kind_reg[k] <= dv_kind_next[k];
                dv_rem_reg[k]  <= dv_rem_next[k];
                dv_den_reg[k]  <= dv_den_next[k];
                dv_q_reg[k]    <= dv_q_next[k];
            end
        end
    end

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (!en) |=> $stable(dv_vld_reg[NS]) && $stable(a_vld_reg))
        else $error("pipeline moved while the output was stalled");
    a_pop_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (!out_vld_reg || m_ready))
        else $error("item taken from the queue during a stall");
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_vld_reg[NS] && dv_kind_reg[NS] == hdt_pkg::KIND_RAMP)
            |-> dv_rem_reg[NS] < {10'b0, dv_den_reg[NS]})
        else $error("divider remainder not reduced");

endmodule

/* tb/tb_halftone_dot_screen_texel.sv */
// Self-checking testbench for the clustered-dot halftone screen texel block.
// Depends on hdt_pkg and halftone_dot_screen_texel; predicts each coverage byte in SystemVerilog.
module tb_halftone_dot_screen_texel;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 11;
    localparam int CYCLE_LIMIT = 400000;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [3:0] s_level;
    logic [7:0] s_pos_x;
    logic [7:0] s_pos_y;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_coverage;
    logic       cfg_wr_en;
    logic [0:0] cfg_index;
    logic [4:0] cfg_wdata;

    logic [3:0] cur_tex_shift;
    logic [4:0] cur_levels;
    logic [7:0] coverage_due[$];
    int         n_errors;
    int         n_items;
    int         n_results;
    int         cycle_count;
    bit         hold_off_req;
    bit         stall_on;

    halftone_dot_screen_texel i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_level    (s_level),
        .s_pos_x    (s_pos_x),
        .s_pos_y    (s_pos_y),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_coverage (m_coverage),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    function automatic logic [63:0] root_floor(input logic [63:0] val);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 0;
        hi = 64'd4294967296;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= val) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic logic [63:0] fold_dist(input logic [7:0] p, input logic [63:0] c);
        logic [63:0] x;
        x = 64'(p) & (c - 1);
        return (x <= c / 2) ? x : c - x;
    endfunction

    function automatic logic [7:0] texel_coverage(input logic [3:0] level,
                                                  input logic [7:0] px, input logic [7:0] py);
        logic [63:0] sl, nl, c, b, half_tile, radius, r, s, t, f, dx, dy, d, lo_b, lo, hi;
        sl = (cur_tex_shift > hdt_pkg::MAX_SIZE_LOG2) ? hdt_pkg::MAX_SIZE_LOG2 : cur_tex_shift;
        nl = cur_levels;
        if (nl < 2) nl = 2;
        if (nl > hdt_pkg::MAX_LEVELS) nl = hdt_pkg::MAX_LEVELS;
        c = (sl >= 3) ? 8 : (64'd1 << sl);
        if (level == 0) return 8'd0;
        if (64'(level) >= nl - 1) return 8'd255;
        b = (64'(level) * 65536) / nl;
        half_tile = 16 * c;
        if (b < 51472) begin
            r = (b * 65536) / 51472;
            s = root_floor(r * 65536);
            radius = (s * half_tile) / 65536;
        end else begin
            t = ((b - 51472) * 65536) / (65536 - 51472);
            f = 65536 + (27146 * t) / 65536;
            radius = (f * half_tile) / 65536;
        end
        if (radius == 0) return 8'd0;
        dx = fold_dist(px, c);
        dy = fold_dist(py, c);
        d = (dx * dx + dy * dy) * 1024;
        lo_b = (radius >= 16) ? radius - 16 : 16 - radius;
        lo = lo_b * lo_b;
        hi = (radius + 16) * (radius + 16);
        if (d < lo) return 8'd255;
        if (d < hi) return 8'((255 * (hi - d)) / (hi - lo));
        return 8'd0;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got %0d expected %0d", n_results, what, got, want);
        n_errors++;
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) @(posedge aclk);
    endtask

    function automatic int random_gap();
        if ($urandom_range(0, 99) < 50) return 0;
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Valid stays high between items sent back to back; it drops only for a gap.
    task automatic send_texel(input logic [3:0] level, input logic [7:0] px,
                              input logic [7:0] py, input bit gaps);
        int gap;
        gap = gaps ? random_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            idle_cycles(gap);
        end
        s_valid <= 1'b1;
        s_level <= level;
        s_pos_x <= px;
        s_pos_y <= py;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        coverage_due.push_back(texel_coverage(level, px, py));
        n_items++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (coverage_due.size() != 0) @(posedge aclk);
        idle_cycles(LATENCY + 4);
    endtask

    // Registers are written only with the pipeline empty.
    task automatic write_reg(input logic [0:0] idx, input logic [4:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == hdt_pkg::REG_TEX_SHIFT) cur_tex_shift = val[3:0];
        else cur_levels = val;
        @(posedge aclk);
    endtask

    // Result checker.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (coverage_due.size() == 0) begin
                report_mismatch("unexpected item, coverage", m_coverage, -1);
            end else begin
                if (m_coverage !== coverage_due[0])
                    report_mismatch("coverage", m_coverage, coverage_due[0]);
                void'(coverage_due.pop_front());
            end
        end
    end

    // Receiver with its own random stall pattern, plus a hold-off when hold_off_req is set.
    initial begin
        int n;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                n = 0;
                while (n < 60) begin
                    @(posedge aclk);
                    n++;
                end
                hold_off_req = 1'b0;
            end else if (stall_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                idle_cycles(random_gap() + 1);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_halftone_dot_screen_texel failed");
            $finish;
        end
    end

    task automatic test_directed();
        logic [3:0] lv;
        logic [7:0] edges[4];
        edges = '{8'd0, 8'd4, 8'd7, 8'd255};
        for (int i = 0; i < 4; i++)
            send_texel(4'd0, edges[i], edges[3 - i], 1'b0);
        send_texel(4'd15, 8'd0, 8'd0, 1'b0);
        send_texel(4'd15, 8'd255, 8'd170, 1'b0);
        for (int i = 1; i < 15; i++) begin
            lv = 4'(i);
            send_texel(lv, 8'(i * 17), 8'(255 - i * 9), 1'b0);
        end
        send_texel(4'd7, 8'h55, 8'hAA, 1'b0);
        send_texel(4'd8, 8'hAA, 8'h55, 1'b0);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_texel(4'($urandom_range(0, 15)), 8'($urandom), 8'($urandom), 1'b1);
    endtask

    task automatic test_back_pressure();
        hold_off_req = 1'b1;
        for (int i = 0; i < 20; i++)
            send_texel(4'($urandom_range(1, 14)), 8'($urandom), 8'($urandom), 1'b0);
        drain();
        test_random(10);
    endtask

    task automatic test_config_sweep();
        logic [4:0] sizes[6];
        logic [4:0] levels[6];
        sizes = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd15, 5'd9};
        levels = '{5'd0, 5'd1, 5'd2, 5'd31, 5'd16, 5'd11};
        for (int i = 0; i < 6; i++) begin
            write_reg(hdt_pkg::REG_TEX_SHIFT, sizes[i]);
            write_reg(hdt_pkg::REG_LEVEL_COUNT, levels[5 - i]);
            test_random(60);
            write_reg(hdt_pkg::REG_LEVEL_COUNT, levels[i]);
            test_random(60);
        end
        write_reg(hdt_pkg::REG_TEX_SHIFT, 5'd8);
        write_reg(hdt_pkg::REG_LEVEL_COUNT, 5'd16);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_level = '0;
        s_pos_x = '0;
        s_pos_y = '0;
        cfg_wr_en = 1'b0;
        cfg_index = hdt_pkg::REG_TEX_SHIFT;
        cfg_wdata = '0;
        cur_tex_shift = 4'd8;
        cur_levels = 5'd16;
        n_errors = 0;
        n_items = 0;
        n_results = 0;
        cycle_count = 0;
        hold_off_req = 1'b0;
        stall_on = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        stall_on = 1'b1;
        test_random(150);
        test_back_pressure();
        test_config_sweep();
        stall_on = 1'b0;
        test_random(180);
        stall_on = 1'b1;
        drain();
        $display("covered %0d texels (%0d results) over size and level count settings",
                 n_items, n_results);
        if (n_errors == 0 && coverage_due.size() == 0) begin
            $display("tb_halftone_dot_screen_texel passed");
        end else begin
            $display("%0d mismatches, %0d results missing", n_errors, coverage_due.size());
            $display("tb_halftone_dot_screen_texel failed");
        end
        $finish;
    end
endmodule

/* files.f */
sv/hdt_pkg.sv
sv/hdt_front.sv
sv/hdt_fifo.sv
sv/hdt_back.sv
sv/halftone_dot_screen_texel.sv
tb/tb_halftone_dot_screen_texel.sv
